// ===== rtl/core/lbds_pkg.sv =====
// Package with the codes, register indexes and payload types of the dimmer sequencer.
package lbds_pkg;

   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_POLL = 2'd1;
   localparam logic [1:0] OP_DONE = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   localparam logic [1:0] EV_OK      = 2'd0;
   localparam logic [1:0] EV_TIMEOUT = 2'd1;
   localparam logic [1:0] EV_FAULT   = 2'd2;
   localparam logic [1:0] EV_OTHER   = 2'd3;

   localparam logic [1:0] LOCK_FREE = 2'd0;
   localparam logic [1:0] LOCK_OWN  = 2'd1;

   localparam logic [1:0] CSR_PHYS_MIN  = 2'd0;
   localparam logic [1:0] CSR_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_REQ_LIMIT = 2'd2;

   localparam logic [7:0] PHYS_MIN_RESET  = 8'd0;
   localparam logic [7:0] OFFSET_RESET    = 8'd1;
   localparam logic [7:0] REQ_LIMIT_RESET = 8'd253;

   localparam logic [4:0] CMD_UNKNOWN        = 5'd0;
   localparam logic [4:0] CMD_SET_POWER_ON   = 5'd1;
   localparam logic [4:0] CMD_QRY_POWER_ON   = 5'd2;
   localparam logic [4:0] CMD_SET_SYS_FAIL   = 5'd3;
   localparam logic [4:0] CMD_QRY_SYS_FAIL   = 5'd4;
   localparam logic [4:0] CMD_DAPC           = 5'd5;
   localparam logic [4:0] CMD_QRY_STATUS     = 5'd6;
   localparam logic [4:0] CMD_LED_FIRST      = 5'd7;
   localparam logic [4:0] CMD_LED_LAST       = 5'd14;
   localparam logic [4:0] CMD_QRY_FAILURE    = 5'd15;
   localparam logic [4:0] CMD_QRY_ACTUAL     = 5'd16;
   localparam logic [4:0] CMD_GEAR_FIRST     = 5'd17;
   localparam logic [4:0] CMD_GEAR_LAST      = 5'd23;

   localparam logic [7:0] STATUS_BIT [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h20, 8'h40, 8'h80};

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] req_level;
      logic [1:0] addr_method;
      logic [7:0] addr_value;
      logic [4:0] done_command;
      logic [1:0] bus_event;
      logic [7:0] reply_data;
      logic [1:0] lock_owner;
   } req_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [4:0] cmd_code;
      logic [1:0] cmd_method;
      logic [7:0] cmd_address;
      logic [7:0] cmd_payload;
      logic       busy_res;
      logic       lock_take;
      logic       lock_release;
      logic [7:0] level_report;
      logic [7:0] status_report;
      logic [7:0] failure_report;
   } rsp_type;

endpackage

// ===== rtl/core/lbds_req_if.sv =====
// Request channel interface of the dimmer sequencer.
interface lbds_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] req_level;
   logic [1:0] addr_method;
   logic [7:0] addr_value;
   logic [4:0] done_command;
   logic [1:0] bus_event;
   logic [7:0] reply_data;
   logic [1:0] lock_owner;

   modport source (output valid, output opcode, output req_level, output addr_method,
      output addr_value, output done_command, output bus_event, output reply_data,
      output lock_owner, input ready);
   modport sink (input valid, input opcode, input req_level, input addr_method,
      input addr_value, input done_command, input bus_event, input reply_data,
      input lock_owner, output ready);
endinterface

// ===== rtl/core/lbds_rsp_if.sv =====
// Result channel interface of the dimmer sequencer.
interface lbds_rsp_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [4:0] cmd_code;
   logic [1:0] cmd_method;
   logic [7:0] cmd_address;
   logic [7:0] cmd_payload;
   logic       busy_res;
   logic       lock_take;
   logic       lock_release;
   logic [7:0] level_report;
   logic [7:0] status_report;
   logic [7:0] failure_report;

   modport source (output valid, output cmd_valid, output cmd_code, output cmd_method,
      output cmd_address, output cmd_payload, output busy_res, output lock_take,
      output lock_release, output level_report, output status_report,
      output failure_report, input ready);
   modport sink (input valid, input cmd_valid, input cmd_code, input cmd_method,
      input cmd_address, input cmd_payload, input busy_res, input lock_take,
      input lock_release, input level_report, input status_report,
      input failure_report, output ready);
endinterface

// ===== rtl/core/lbds_csr_if.sv =====
// Configuration write channel interface of the dimmer sequencer.
interface lbds_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lighting_bus_dimmer_sequencer.sv =====
// Top level of the lighting bus dimmer command sequencer.
// Every request transfer yields exactly one result transfer. A request is captured in an
// input register, decoded against the node state once the result register can take it,
// and written to the result register; one request is taken every cycle while the result
// side keeps up. The node state is updated in the decode cycle, which lets each request
// see the effect of the one before it. Configuration writes are always ready and take
// effect at once; indexes beyond the three registers are ignored.
module lighting_bus_dimmer_sequencer
   import lbds_pkg::*;
(
   input logic        clock,
   input logic        reset,
   lbds_req_if.sink   req_chan,
   lbds_rsp_if.source rsp_chan,
   lbds_csr_if.sink   csr_chan
);

   logic [7:0] phys_min_ff;
   logic [7:0] offset_ff;
   logic [7:0] req_limit_ff;

   logic       stage_valid_ff, stage_valid_in;
   req_type    stage_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic [1:0] node_method_ff, node_method_in;
   logic [7:0] node_address_ff, node_address_in;
   logic [7:0] target_level_ff, target_level_in;
   logic [7:0] actual_level_ff, actual_level_in;
   logic [7:0] gear_status_ff, gear_status_in;
   logic [7:0] led_failure_ff, led_failure_in;

   logic       advance;
   logic       req_xfer;
   logic       do_push;
   logic [4:0] push_code;
   logic [7:0] clamped;
   logic [8:0] offset_sum;
   logic [7:0] raised;
   logic       ok, tmo, flt;
   logic [4:0] code;
   logic [7:0] reply;
   logic [7:0] led_bit;
   logic [7:0] gear_bit;

   assign advance  = stage_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign stage_valid_in = req_xfer || (stage_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   assign code  = stage_ff.done_command;
   assign reply = stage_ff.reply_data;
   assign ok    = (stage_ff.bus_event == EV_OK);
   assign tmo   = (stage_ff.bus_event == EV_TIMEOUT);
   assign flt   = (stage_ff.bus_event == EV_FAULT);

   assign led_bit  = 8'b1 << 3'(code + 5'd1);
   assign gear_bit = STATUS_BIT[3'(code - CMD_GEAR_FIRST)];

   assign clamped    = (stage_ff.req_level > req_limit_ff) ? req_limit_ff : stage_ff.req_level;
   assign offset_sum = {1'b0, clamped} + {1'b0, offset_ff};

   always_comb begin
      if (clamped == 8'd0) begin
         raised = 8'd0;
      end else begin
         raised = offset_sum[8] ? 8'hFF : offset_sum[7:0];
         if (phys_min_ff != 8'd0 && raised < phys_min_ff) begin
            raised = phys_min_ff;
         end
      end
   end

   always_comb begin
      node_method_in  = node_method_ff;
      node_address_in = node_address_ff;
      target_level_in = target_level_ff;
      actual_level_in = actual_level_ff;
      gear_status_in  = gear_status_ff;
      led_failure_in  = led_failure_ff;
      out_in          = '0;
      do_push         = 1'b0;
      push_code       = CMD_UNKNOWN;
      if (advance) begin
         case (stage_ff.opcode)
            OP_SET: begin
               if (stage_ff.lock_owner inside {LOCK_FREE, LOCK_OWN}) begin
                  out_in.lock_take = (stage_ff.lock_owner == LOCK_FREE);
                  target_level_in  = raised;
                  node_method_in   = stage_ff.addr_method;
                  node_address_in  = stage_ff.addr_value;
                  do_push          = 1'b1;
                  push_code        = CMD_SET_POWER_ON;
               end else begin
                  out_in.busy_res = 1'b1;
               end
            end
            OP_POLL: begin
               out_in.level_report   = (actual_level_ff > offset_ff) ?
                                       actual_level_ff - offset_ff : 8'd0;
               out_in.status_report  = gear_status_ff;
               out_in.failure_report = led_failure_ff;
               node_method_in        = stage_ff.addr_method;
               node_address_in       = stage_ff.addr_value;
               if (stage_ff.lock_owner == LOCK_FREE) begin
                  out_in.lock_take = 1'b1;
                  do_push          = 1'b1;
                  push_code        = CMD_GEAR_FIRST;
               end
            end
            OP_DONE: begin
               case (code)
                  CMD_UNKNOWN: begin
                     do_push   = 1'b1;
                     push_code = CMD_SET_POWER_ON;
                  end
                  CMD_SET_POWER_ON, CMD_SET_SYS_FAIL, CMD_DAPC: begin
                     do_push   = ok;
                     push_code = code + 5'd1;
                  end
                  CMD_QRY_POWER_ON, CMD_QRY_SYS_FAIL: begin
                     do_push   = 1'b1;
                     push_code = (ok && reply == target_level_ff) ? code + 5'd1 : code - 5'd1;
                  end
                  CMD_QRY_STATUS: begin
                     if (!flt) begin
                        if (ok) begin
                           gear_status_in = gear_status_ff | reply;
                        end
                        do_push   = 1'b1;
                        push_code = CMD_LED_FIRST;
                     end
                  end
                  CMD_QRY_FAILURE: begin
                     if (!flt) begin
                        if (ok) begin
                           led_failure_in = led_failure_ff | reply;
                        end
                        do_push   = 1'b1;
                        push_code = CMD_QRY_ACTUAL;
                     end
                  end
                  CMD_QRY_ACTUAL: begin
                     if (ok) begin
                        actual_level_in = reply;
                        out_in.lock_release = (reply == target_level_ff) &&
                           ((phys_min_ff != 8'd0 && target_level_ff >= phys_min_ff) ||
                            target_level_ff == 8'd0);
                     end
                  end
                  default: begin
                     if (code inside {[CMD_LED_FIRST:CMD_LED_LAST]}) begin
                        if (ok) begin
                           led_failure_in = led_failure_ff | led_bit;
                        end else if (tmo) begin
                           led_failure_in = led_failure_ff & ~led_bit;
                        end
                        do_push   = ok || tmo;
                        push_code = code + 5'd1;
                     end else if (code inside {[CMD_GEAR_FIRST:CMD_GEAR_LAST]}) begin
                        if ((code == CMD_GEAR_FIRST) ? tmo : ok) begin
                           gear_status_in = gear_status_ff | gear_bit;
                        end else if ((code == CMD_GEAR_FIRST) ? ok : tmo) begin
                           gear_status_in = gear_status_ff & ~gear_bit;
                        end
                        do_push   = 1'b1;
                        push_code = (code == CMD_GEAR_LAST) ? CMD_QRY_STATUS : code + 5'd1;
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      if (do_push) begin
         out_in.cmd_valid   = 1'b1;
         out_in.cmd_code    = push_code;
         out_in.cmd_method  = node_method_in;
         out_in.cmd_address = node_address_in;
         out_in.cmd_payload = (push_code inside {CMD_SET_POWER_ON, CMD_SET_SYS_FAIL, CMD_DAPC}) ?
                              target_level_in : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_min_ff     <= PHYS_MIN_RESET;
         offset_ff       <= OFFSET_RESET;
         req_limit_ff    <= REQ_LIMIT_RESET;
         stage_valid_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
         node_method_ff  <= '0;
         node_address_ff <= '0;
         target_level_ff <= '0;
         actual_level_ff <= '0;
         gear_status_ff  <= '0;
         led_failure_ff  <= '0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_PHYS_MIN:  phys_min_ff  <= csr_chan.data;
               CSR_OFFSET:    offset_ff    <= csr_chan.data;
               CSR_REQ_LIMIT: req_limit_ff <= csr_chan.data;
               default: begin
               end
            endcase
         end
         stage_valid_ff  <= stage_valid_in;
         out_valid_ff    <= out_valid_in;
         node_method_ff  <= node_method_in;
         node_address_ff <= node_address_in;
         target_level_ff <= target_level_in;
         actual_level_ff <= actual_level_in;
         gear_status_ff  <= gear_status_in;
         led_failure_ff  <= led_failure_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_ff.opcode       <= req_chan.opcode;
         stage_ff.req_level    <= req_chan.req_level;
         stage_ff.addr_method  <= req_chan.addr_method;
         stage_ff.addr_value   <= req_chan.addr_value;
         stage_ff.done_command <= req_chan.done_command;
         stage_ff.bus_event    <= req_chan.bus_event;
         stage_ff.reply_data   <= req_chan.reply_data;
         stage_ff.lock_owner   <= req_chan.lock_owner;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.cmd_valid      = out_ff.cmd_valid;
   assign rsp_chan.cmd_code       = out_ff.cmd_code;
   assign rsp_chan.cmd_method     = out_ff.cmd_method;
   assign rsp_chan.cmd_address    = out_ff.cmd_address;
   assign rsp_chan.cmd_payload    = out_ff.cmd_payload;
   assign rsp_chan.busy_res       = out_ff.busy_res;
   assign rsp_chan.lock_take      = out_ff.lock_take;
   assign rsp_chan.lock_release   = out_ff.lock_release;
   assign rsp_chan.level_report   = out_ff.level_report;
   assign rsp_chan.status_report  = out_ff.status_report;
   assign rsp_chan.failure_report = out_ff.failure_report;

endmodule

// ===== rtl/core/lbds_checker.sv =====
// Port checker for the dimmer sequencer and its binding to the top level.
module lbds_checker
   import lbds_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       cmd_valid,
   input logic [4:0] cmd_code,
   input logic [1:0] cmd_method,
   input logic [7:0] cmd_address,
   input logic [7:0] cmd_payload,
   input logic       busy_res,
   input logic       lock_take,
   input logic       lock_release
);

   // A refused set transfer issues nothing and takes nothing.
   a_busy_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && busy_res |-> !cmd_valid && !lock_take && !lock_release)
      else $error("busy result carries a command or lock action");

   // Without a command all command fields read zero.
   a_idle_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cmd_valid |->
         cmd_code == 5'd0 && cmd_method == 2'd0 && cmd_address == 8'd0 && cmd_payload == 8'd0)
      else $error("command fields set without a command");

   // Queries carry no level.
   a_query_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cmd_valid && cmd_code != CMD_SET_POWER_ON && cmd_code != CMD_SET_SYS_FAIL &&
      cmd_code != CMD_DAPC |-> cmd_payload == 8'd0)
      else $error("query command carries a level");

   // Release ends the chain: no command and no lock take alongside it.
   a_release_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && lock_release |-> !cmd_valid && !lock_take)
      else $error("lock release together with a command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid && !rsp_ready) |->
         rsp_valid && $stable(cmd_code) && $stable(cmd_payload) && $stable(lock_release))
      else $error("stalled result transfer changed");

endmodule

bind lighting_bus_dimmer_sequencer lbds_checker u_lbds_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .cmd_valid    (rsp_chan.cmd_valid),
   .cmd_code     (rsp_chan.cmd_code),
   .cmd_method   (rsp_chan.cmd_method),
   .cmd_address  (rsp_chan.cmd_address),
   .cmd_payload  (rsp_chan.cmd_payload),
   .busy_res     (rsp_chan.busy_res),
   .lock_take    (rsp_chan.lock_take),
   .lock_release (rsp_chan.lock_release)
);

// ===== verif/lbds_node_mirror_pkg.sv =====
// Mirror of the dimmer sequencer node state that predicts and checks every result transfer.
package lbds_tb_pkg;
   import lbds_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   class node_mirror;
      logic [7:0] phys_min;
      logic [7:0] offset;
      logic [7:0] req_limit;
      logic [1:0] node_method;
      logic [7:0] node_address;
      logic [7:0] target;
      logic [7:0] actual;
      logic [7:0] status;
      logic [7:0] failure;
      bit         chain_live;
      logic [4:0] chain_code;
      rsp_type    pending_results[$];
      int         errors;

      function new();
         phys_min     = PHYS_MIN_RESET;
         offset       = OFFSET_RESET;
         req_limit    = REQ_LIMIT_RESET;
         node_method  = '0;
         node_address = '0;
         target       = '0;
         actual       = '0;
         status       = '0;
         failure      = '0;
         chain_live   = 1'b0;
         chain_code   = CMD_UNKNOWN;
         errors       = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_PHYS_MIN:  phys_min = value;
            CSR_OFFSET:    offset = value;
            CSR_REQ_LIMIT: req_limit = value;
            default: ;
         endcase
      endfunction

      function rsp_type issue(rsp_type o, logic [4:0] code);
         o.cmd_valid   = 1'b1;
         o.cmd_code    = code;
         o.cmd_method  = node_method;
         o.cmd_address = node_address;
         o.cmd_payload = (code == CMD_SET_POWER_ON || code == CMD_SET_SYS_FAIL ||
                          code == CMD_DAPC) ? target : 8'd0;
         return o;
      endfunction

      function rsp_type complete(logic [4:0] code, logic [1:0] ev, logic [7:0] reply);
         rsp_type    o;
         bit         ok;
         bit         tmo;
         bit         flt;
         bit         do_set;
         bit         do_clr;
         logic [7:0] mask;
         int         idx;
         o   = '0;
         ok  = (ev == EV_OK);
         tmo = (ev == EV_TIMEOUT);
         flt = (ev == EV_FAULT);
         case (code)
            CMD_UNKNOWN: o = issue(o, CMD_SET_POWER_ON);
            CMD_SET_POWER_ON: if (ok) o = issue(o, CMD_QRY_POWER_ON);
            CMD_QRY_POWER_ON:
               o = issue(o, (ok && reply == target) ? CMD_SET_SYS_FAIL : CMD_SET_POWER_ON);
            CMD_SET_SYS_FAIL: if (ok) o = issue(o, CMD_QRY_SYS_FAIL);
            CMD_QRY_SYS_FAIL:
               o = issue(o, (ok && reply == target) ? CMD_DAPC : CMD_SET_SYS_FAIL);
            CMD_DAPC: if (ok) o = issue(o, CMD_QRY_STATUS);
            CMD_QRY_STATUS: begin
               if (!flt) begin
                  if (ok) status = status | reply;
                  o = issue(o, CMD_LED_FIRST);
               end
            end
            CMD_QRY_FAILURE: begin
               if (!flt) begin
                  if (ok) failure = failure | reply;
                  o = issue(o, CMD_QRY_ACTUAL);
               end
            end
            CMD_QRY_ACTUAL: begin
               if (ok) begin
                  actual = reply;
                  if (((phys_min != 8'd0 && target >= phys_min) || target == 8'd0) &&
                      reply == target) o.lock_release = 1'b1;
               end
            end
            default: begin
               if (code >= CMD_LED_FIRST && code <= CMD_LED_LAST) begin
                  mask = 8'd1 << (code - CMD_LED_FIRST);
                  if (ok) failure = failure | mask;
                  else if (tmo) failure = failure & ~mask;
                  if (ok || tmo) o = issue(o, code + 5'd1);
               end else if (code >= CMD_GEAR_FIRST && code <= CMD_GEAR_LAST) begin
                  idx    = int'(code - CMD_GEAR_FIRST);
                  mask   = (idx < 4) ? (8'd1 << idx) : (8'd1 << (idx + 1));
                  do_set = (code == CMD_GEAR_FIRST) ? tmo : ok;
                  do_clr = (code == CMD_GEAR_FIRST) ? ok : tmo;
                  if (do_set) status = status | mask;
                  else if (do_clr) status = status & ~mask;
                  o = issue(o, (code == CMD_GEAR_LAST) ? CMD_QRY_STATUS : code + 5'd1);
               end
            end
         endcase
         return o;
      endfunction

      function rsp_type decode(req_type r);
         rsp_type o;
         int      lvl;
         o = '0;
         case (r.opcode)
            OP_SET: begin
               if (r.lock_owner != LOCK_FREE && r.lock_owner != LOCK_OWN) begin
                  o.busy_res = 1'b1;
               end else begin
                  o.lock_take = (r.lock_owner == LOCK_FREE);
                  lvl = (r.req_level > req_limit) ? int'(req_limit) : int'(r.req_level);
                  if (lvl != 0) begin
                     lvl = lvl + int'(offset);
                     if (lvl > 255) lvl = 255;
                     if (phys_min != 8'd0 && lvl < int'(phys_min)) lvl = int'(phys_min);
                  end
                  target       = 8'(lvl);
                  node_method  = r.addr_method;
                  node_address = r.addr_value;
                  o = issue(o, CMD_SET_POWER_ON);
               end
            end
            OP_POLL: begin
               o.level_report   = (actual > offset) ? 8'(actual - offset) : 8'd0;
               o.status_report  = status;
               o.failure_report = failure;
               node_method      = r.addr_method;
               node_address     = r.addr_value;
               if (r.lock_owner == LOCK_FREE) begin
                  o.lock_take = 1'b1;
                  o = issue(o, CMD_GEAR_FIRST);
               end
            end
            OP_DONE: o = complete(r.done_command, r.bus_event, r.reply_data);
            default: ;
         endcase
         return o;
      endfunction

      function void take_request(req_type r);
         rsp_type o;
         o = decode(r);
         if (o.cmd_valid) begin
            chain_live = 1'b1;
            chain_code = o.cmd_code;
         end else if (r.opcode == OP_DONE && r.done_command == chain_code) begin
            chain_live = 1'b0;
         end
         pending_results.push_back(o);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void check_field(string name, logic [7:0] exp, logic [7:0] got);
         if (got !== exp) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
            errors++;
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type exp;
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected, expected none, actual %h",
               $time, got);
            errors++;
            return;
         end
         exp = pending_results.pop_front();
         check_field("cmd_valid", 8'(exp.cmd_valid), 8'(got.cmd_valid));
         check_field("cmd_code", 8'(exp.cmd_code), 8'(got.cmd_code));
         check_field("cmd_method", 8'(exp.cmd_method), 8'(got.cmd_method));
         check_field("cmd_address", exp.cmd_address, got.cmd_address);
         check_field("cmd_payload", exp.cmd_payload, got.cmd_payload);
         check_field("busy_res", 8'(exp.busy_res), 8'(got.busy_res));
         check_field("lock_take", 8'(exp.lock_take), 8'(got.lock_take));
         check_field("lock_release", 8'(exp.lock_release), 8'(got.lock_release));
         check_field("level_report", exp.level_report, got.level_report);
         check_field("status_report", exp.status_report, got.status_report);
         check_field("failure_report", exp.failure_report, got.failure_report);
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
// Top of the dimmer sequencer testbench: clock, reset, stimulus, result stall, result monitor and run limit.
module tb_top;
   import lbds_pkg::*;
   import lbds_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 235;
   localparam int PHASE_COUNT  = 8;

   logic clock;
   logic reset;
   bit   hold_off_req = 1'b0;
   int   cycle_count = 0;

   node_mirror mirror = new();

   lbds_req_if req_bus();
   lbds_rsp_if rsp_bus();
   lbds_csr_if csr_bus();

   lighting_bus_dimmer_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = {rsp_bus.cmd_valid, rsp_bus.cmd_code, rsp_bus.cmd_method, rsp_bus.cmd_address,
                 rsp_bus.cmd_payload, rsp_bus.busy_res, rsp_bus.lock_take,
                 rsp_bus.lock_release, rsp_bus.level_report, rsp_bus.status_report,
                 rsp_bus.failure_report};
         mirror.match_result(seen);
      end
   end

   initial begin : result_stall
      int seg_len;
      int mode;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            seg_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic req_type blank_item(logic [1:0] op);
      req_type item;
      item             = '0;
      item.opcode      = op;
      item.addr_method = 2'($urandom_range(0, 3));
      item.addr_value  = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic req_type set_req(logic [7:0] level, logic [1:0] lock);
      req_type item;
      item            = blank_item(OP_SET);
      item.req_level  = level;
      item.lock_owner = lock;
      return item;
   endfunction

   function automatic req_type poll_req(logic [1:0] lock);
      req_type item;
      item            = blank_item(OP_POLL);
      item.lock_owner = lock;
      return item;
   endfunction

   function automatic req_type done_req(logic [4:0] code, logic [1:0] ev, logic [7:0] reply);
      req_type item;
      item              = blank_item(OP_DONE);
      item.done_command = code;
      item.bus_event    = ev;
      item.reply_data   = reply;
      return item;
   endfunction

   function automatic req_type next_random_item();
      req_type    item;
      int         roll;
      logic [4:0] code;
      item.opcode       = 2'($urandom_range(0, 3));
      item.req_level    = 8'($urandom_range(0, 255));
      item.addr_method  = 2'($urandom_range(0, 3));
      item.addr_value   = 8'($urandom_range(0, 255));
      item.done_command = 5'($urandom_range(0, 31));
      item.bus_event    = 2'($urandom_range(0, 3));
      item.reply_data   = 8'($urandom_range(0, 255));
      item.lock_owner   = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 12) return item;
      if (!mirror.chain_live || roll < 24) begin
         item.opcode = ($urandom_range(0, 2) != 0) ? OP_SET : OP_POLL;
         roll = $urandom_range(0, 9);
         if (roll == 0) item.req_level = 8'd0;
         else if (roll == 1) item.req_level = 8'd255;
         else if (roll == 2) item.req_level = 8'(mirror.req_limit + 8'($urandom_range(0, 1)));
         roll = $urandom_range(0, 19);
         if (roll < 9) item.lock_owner = LOCK_FREE;
         else if (roll < 17) item.lock_owner = LOCK_OWN;
         else item.lock_owner = 2'($urandom_range(2, 3));
         return item;
      end
      code              = mirror.chain_code;
      item.opcode       = OP_DONE;
      item.done_command = code;
      roll = $urandom_range(0, 99);
      if (roll < 78) item.bus_event = EV_OK;
      else if (roll < 88) item.bus_event = EV_TIMEOUT;
      else if (roll < 94) item.bus_event = EV_FAULT;
      else item.bus_event = EV_OTHER;
      roll = $urandom_range(0, 99);
      if (code == CMD_QRY_POWER_ON || code == CMD_QRY_SYS_FAIL) begin
         if (roll < 85) item.reply_data = mirror.target;
      end else if (code == CMD_QRY_ACTUAL) begin
         if (roll < 60) item.reply_data = mirror.target;
      end else if (roll < 50) begin
         item.reply_data = 8'd1 << $urandom_range(0, 7);
      end
      return item;
   endfunction

   task automatic offer_item(req_type item);
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= item.opcode;
      req_bus.req_level    <= item.req_level;
      req_bus.addr_method  <= item.addr_method;
      req_bus.addr_value   <= item.addr_value;
      req_bus.done_command <= item.done_command;
      req_bus.bus_event    <= item.bus_event;
      req_bus.reply_data   <= item.reply_data;
      req_bus.lock_owner   <= item.lock_owner;
      do @(posedge clock); while (!req_bus.ready);
      mirror.take_request(item);
   endtask

   task automatic rest(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_reg(logic [1:0] idx, logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      mirror.write_reg(idx, value);
   endtask

   task automatic apply_setting(int phase);
      logic [7:0] pm;
      logic [7:0] off;
      logic [7:0] lim;
      pm  = 8'($urandom_range(0, 254));
      off = 8'($urandom_range(0, 254));
      lim = 8'($urandom_range(0, 254));
      case (phase)
         0: begin pm = 8'd0;   off = 8'd1;   lim = 8'd253; end
         1: begin pm = 8'd254; off = 8'd254; lim = 8'd254; end
         2: begin pm = 8'd0;   off = 8'd0;   lim = 8'd0;   end
         3: begin pm = 8'd10;  off = 8'd5;   lim = 8'd200; end
         5: begin pm = 8'd254; off = 8'd0;   lim = 8'd254; end
         6: begin pm = 8'd0;   off = 8'd254; lim = 8'd254; end
         default: ;
      endcase
      wait_drained();
      program_reg(CSR_PHYS_MIN, pm);
      program_reg(CSR_OFFSET, off);
      program_reg(CSR_REQ_LIMIT, lim);
      if (phase == 4) program_reg(CSR_UNUSED, 8'($urandom_range(0, 255)));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int count, bit with_hold, bit with_pause);
      int sent;
      int burst;
      int gap;
      sent = 0;
      if (with_hold) begin
         hold_off_req = 1'b1;
         repeat (50) begin
            offer_item(next_random_item());
            sent++;
         end
      end
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if (with_pause && sent == count / 2) wait_drained();
            offer_item(next_random_item());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) rest(gap);
      end
   endtask

   initial begin : stimulus
      req_type directed[$];
      req_type nop_item;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_NOP;
      req_bus.req_level    <= '0;
      req_bus.addr_method  <= '0;
      req_bus.addr_value   <= '0;
      req_bus.done_command <= '0;
      req_bus.bus_event    <= '0;
      req_bus.reply_data   <= '0;
      req_bus.lock_owner   <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      repeat (3) @(posedge clock);

      nop_item = blank_item(OP_NOP);
      directed.push_back(set_req(8'd255, LOCK_FREE));
      directed.push_back(done_req(CMD_SET_POWER_ON, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_QRY_POWER_ON, EV_OK, 8'd7));
      directed.push_back(done_req(CMD_QRY_POWER_ON, EV_OK, 8'd254));
      directed.push_back(done_req(CMD_SET_SYS_FAIL, EV_TIMEOUT, 8'd0));
      directed.push_back(done_req(CMD_QRY_SYS_FAIL, EV_FAULT, 8'd254));
      directed.push_back(done_req(CMD_QRY_SYS_FAIL, EV_OK, 8'd254));
      directed.push_back(done_req(CMD_DAPC, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_QRY_STATUS, EV_OK, 8'hA5));
      directed.push_back(done_req(CMD_LED_FIRST, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_LED_FIRST + 5'd2, EV_TIMEOUT, 8'd0));
      directed.push_back(done_req(CMD_LED_LAST, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_QRY_FAILURE, EV_OK, 8'h3C));
      directed.push_back(done_req(CMD_QRY_ACTUAL, EV_OK, 8'd254));
      directed.push_back(poll_req(LOCK_FREE));
      directed.push_back(done_req(CMD_GEAR_FIRST, EV_TIMEOUT, 8'd0));
      directed.push_back(done_req(CMD_GEAR_FIRST + 5'd1, EV_FAULT, 8'd0));
      directed.push_back(done_req(CMD_GEAR_LAST, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_QRY_STATUS, EV_FAULT, 8'hFF));
      directed.push_back(done_req(CMD_LED_FIRST + 5'd3, EV_OTHER, 8'd0));
      directed.push_back(set_req(8'd2, 2'd2));
      directed.push_back(set_req(8'd0, 2'd3));
      directed.push_back(set_req(8'd0, LOCK_OWN));
      directed.push_back(done_req(CMD_QRY_ACTUAL, EV_OK, 8'd0));
      directed.push_back(done_req(CMD_UNKNOWN, EV_FAULT, 8'd0));
      directed.push_back(poll_req(LOCK_OWN));
      directed.push_back(nop_item);
      directed.push_back(done_req(5'd31, EV_OK, 8'hFF));
      foreach (directed[i]) offer_item(directed[i]);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_setting(phase);
         send_random(PHASE_ITEMS, phase == 2, phase == 4);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
